### hdl/mid_pkg.sv
// shared types and constants of the multi-input debouncer
package mid_pkg;

  localparam int NUM_PINS = 6;
  localparam int NUM_LANES = 5;
  localparam int ACT_BIT = 1;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLL_INTERVAL_MS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_HIGH_MASK = 2'd2;

  localparam logic [15:0] DEBOUNCE_MS_RST = 16'd30;
  localparam logic [15:0] POLL_INTERVAL_MS_RST = 16'd10;
  localparam logic [NUM_PINS-1:0] ACTIVE_HIGH_MASK_RST = 6'h3f;

  // pin position of each debounced lane
  localparam logic [2:0] LANE_PIN [NUM_LANES] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5};

  localparam int LANE_POWER_BTN = 2;
  localparam int LANE_RESET_BTN = 3;
  localparam int LANE_DEBUG_BTN = 4;

  typedef struct packed {
    logic stable;
    logic rise;
    logic fall;
  } lane_out_t;

  typedef struct packed {
    logic       step;
    logic       started;
    logic       poll_due;
  } lane_ctl_t;

  typedef struct packed {
    logic [NUM_PINS-1:0] stable_levels;
    logic                power_pressed;
    logic                power_released;
    logic                reset_pressed;
    logic                debug_pressed;
    logic                activity_edge;
  } result_t;

endpackage

### hdl/multi_input_debouncer_core.sv
// top level of the multi-input timestamp debouncer
//
// Each input transaction carries a millisecond timestamp, six raw pin levels
// and a request to read and clear the sticky activity-edge flag; each one
// produces exactly one result transaction with the debounced levels and the
// press/release pulses. Both channels move a transaction on a clock edge with
// valid high and stall low.
// Five debounce lanes evaluate their pins in parallel in the cycle a
// transaction is accepted; the merge logic handles the poll timer and the
// activity edge. One transaction is taken every cycle while in_stall is low;
// its result is registered in the output register, else in the skid entry.
// When out_stall is held, one more transaction is parked in a skid entry and
// then in_stall rises; it falls in the cycle after the receiver takes a result.
// Registers are written through cfg_valid/cfg_ready (always ready): 0 debounce
// time, 1 poll interval, 2 polarity mask; other indexes are ignored. The user
// writes only while no transaction is in flight; the block does not enforce it.
// Synchronous reset (rst_n low) empties the output side, restores register
// defaults and makes the next transaction load the pin state without pulses.
module multi_input_debouncer_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [31:0]                           in_now_ms,
  input  logic [5:0]                            in_raw_levels,
  input  logic                                  in_take_activity_edge,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [5:0]                            out_stable_levels,
  output logic                                  out_power_pressed,
  output logic                                  out_power_released,
  output logic                                  out_reset_pressed,
  output logic                                  out_debug_pressed,
  output logic                                  out_activity_edge,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mid_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [15:0]                           cfg_data
);

  logic [15:0]                      debounce_ms_r;
  logic [15:0]                      poll_interval_ms_r;
  logic [mid_pkg::NUM_PINS-1:0]     active_high_mask_r;
  logic [TIME_BITS-1:0]             now;
  logic [mid_pkg::NUM_PINS-1:0]     norm;
  logic                             step;
  mid_pkg::lane_ctl_t               ctl;
  mid_pkg::lane_out_t               lanes [mid_pkg::NUM_LANES];
  mid_pkg::result_t                 result;
  mid_pkg::result_t                 out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r      <= mid_pkg::DEBOUNCE_MS_RST;
      poll_interval_ms_r <= mid_pkg::POLL_INTERVAL_MS_RST;
      active_high_mask_r <= mid_pkg::ACTIVE_HIGH_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mid_pkg::CFG_DEBOUNCE_MS:      debounce_ms_r      <= cfg_data;
        mid_pkg::CFG_POLL_INTERVAL_MS: poll_interval_ms_r <= cfg_data;
        mid_pkg::CFG_ACTIVE_HIGH_MASK: active_high_mask_r <= cfg_data[mid_pkg::NUM_PINS-1:0];
        default: ;
      endcase
    end
  end

  generate
    if (TIME_BITS > 32) begin : g_time_wide
      assign now = {{(TIME_BITS-32){1'b0}}, in_now_ms};
    end else if (TIME_BITS == 32) begin : g_time_same
      assign now = in_now_ms;
    end else begin : g_time_narrow
      assign now = in_now_ms[TIME_BITS-1:0];
    end
  endgenerate

  // a clear mask bit marks an active-low pin
  assign norm = in_raw_levels ^ ~active_high_mask_r;
  assign step = in_valid && !in_stall;

  for (genvar i = 0; i < mid_pkg::NUM_LANES; i++) begin : g_lane
    mid_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .now         (now),
      .level       (norm[mid_pkg::LANE_PIN[i]]),
      .debounce_ms (debounce_ms_r),
      .lane_out    (lanes[i])
    );
  end

  mid_merge #(
    .TIME_BITS (TIME_BITS)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .now              (now),
    .norm             (norm),
    .take             (in_take_activity_edge),
    .poll_interval_ms (poll_interval_ms_r),
    .lanes            (lanes),
    .ctl              (ctl),
    .result           (result)
  );

  mid_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_stable_levels  = out_data.stable_levels;
  assign out_power_pressed  = out_data.power_pressed;
  assign out_power_released = out_data.power_released;
  assign out_reset_pressed  = out_data.reset_pressed;
  assign out_debug_pressed  = out_data.debug_pressed;
  assign out_activity_edge  = out_data.activity_edge;

endmodule

### hdl/mid_lane.sv
// one debounce lane: candidate, stable level and change timestamp of a single pin
module mid_lane #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mid_pkg::lane_ctl_t     ctl,
  input  logic [TIME_BITS-1:0]   now,
  input  logic                   level,
  input  logic [15:0]            debounce_ms,
  output mid_pkg::lane_out_t     lane_out
);

  logic                 cand_r, cand_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  logic [TIME_BITS-1:0] held;
  logic                 settle;

  always_comb begin
    cand_nxt        = cand_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    held            = '0;
    settle          = 1'b0;
    lane_out        = '0;
    if (ctl.step && !ctl.started) begin
      cand_nxt        = level;
      stable_nxt      = level;
      change_time_nxt = now;
    end else if (ctl.step && ctl.poll_due) begin
      if (level != cand_r) begin
        cand_nxt        = level;
        change_time_nxt = now;
      end
      // time since the candidate last changed, wrapping
      held   = now - change_time_nxt;
      settle = (stable_r != cand_nxt) && (held >= TIME_BITS'(debounce_ms));
      if (settle) begin
        stable_nxt    = cand_nxt;
        lane_out.rise = cand_nxt;
        lane_out.fall = !cand_nxt;
      end
    end
    lane_out.stable = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r        <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
    end else begin
      cand_r        <= cand_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
    end
  end

endmodule

### hdl/mid_merge.sv
// shared control (start, poll timer, activity edge) and merge of the lane results
module mid_merge #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [TIME_BITS-1:0]            now,
  input  logic [mid_pkg::NUM_PINS-1:0]    norm,
  input  logic                            take,
  input  logic [15:0]                     poll_interval_ms,
  input  mid_pkg::lane_out_t              lanes [mid_pkg::NUM_LANES],
  output mid_pkg::lane_ctl_t              ctl,
  output mid_pkg::result_t                result
);

  logic                 started_r, started_nxt;
  logic [TIME_BITS-1:0] last_poll_r, last_poll_nxt;
  logic                 pending_r, pending_nxt;
  logic                 prev_act_r, prev_act_nxt;
  logic [TIME_BITS-1:0] since_poll;
  logic                 act;
  logic                 poll_due;

  assign act        = norm[mid_pkg::ACT_BIT];
  assign since_poll = now - last_poll_r;
  assign poll_due   = since_poll >= TIME_BITS'(poll_interval_ms);

  assign ctl.step     = step;
  assign ctl.started  = started_r;
  assign ctl.poll_due = poll_due;

  always_comb begin
    started_nxt   = started_r;
    last_poll_nxt = last_poll_r;
    pending_nxt   = pending_r;
    prev_act_nxt  = prev_act_r;
    result        = '0;
    if (step) begin
      started_nxt = 1'b1;
      if (started_r) begin
        if (act && !prev_act_r) begin
          pending_nxt = 1'b1;
        end
        if (poll_due) begin
          last_poll_nxt = now;
        end
      end
      prev_act_nxt = act;
      // an edge seen on this transaction is returned by a take on it
      if (take) begin
        result.activity_edge = pending_nxt;
        pending_nxt          = 1'b0;
      end
    end
    for (int i = 0; i < mid_pkg::NUM_LANES; i++) begin
      result.stable_levels[mid_pkg::LANE_PIN[i]] = lanes[i].stable;
    end
    result.stable_levels[mid_pkg::ACT_BIT] = act;
    result.power_pressed  = lanes[mid_pkg::LANE_POWER_BTN].rise;
    result.power_released = lanes[mid_pkg::LANE_POWER_BTN].fall;
    result.reset_pressed  = lanes[mid_pkg::LANE_RESET_BTN].rise;
    result.debug_pressed  = lanes[mid_pkg::LANE_DEBUG_BTN].rise;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      last_poll_r <= '0;
      pending_r   <= 1'b0;
      prev_act_r  <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      last_poll_r <= last_poll_nxt;
      pending_r   <= pending_nxt;
      prev_act_r  <= prev_act_nxt;
    end
  end

endmodule

### hdl/mid_skid.sv
// output register with a skid entry so the input side never waits on out_stall directly
module mid_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mid_pkg::result_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mid_pkg::result_t  out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  mid_pkg::result_t out_data_r, out_data_nxt;
  mid_pkg::result_t skid_data_r, skid_data_nxt;
  logic             accept;
  logic             taken;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign taken     = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (taken) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || taken) begin
        out_data_nxt  = in_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = in_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (taken) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

### tb/sv/multi_input_debouncer_core_test.sv
// self-checking testbench of the multi-input timestamp debouncer core
module multi_input_debouncer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [31:0]                  now;
    logic [mid_pkg::NUM_PINS-1:0] raw;
    logic                         take;
  } pin_sample_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [31:0]                      in_now_ms = '0;
  logic [5:0]                       in_raw_levels = '0;
  logic                             in_take_activity_edge = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [5:0]                       out_stable_levels;
  logic                             out_power_pressed;
  logic                             out_power_released;
  logic                             out_reset_pressed;
  logic                             out_debug_pressed;
  logic                             out_activity_edge;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mid_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0]                      cfg_data = '0;

  multi_input_debouncer_core u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_now_ms             (in_now_ms),
    .in_raw_levels         (in_raw_levels),
    .in_take_activity_edge (in_take_activity_edge),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_stable_levels     (out_stable_levels),
    .out_power_pressed     (out_power_pressed),
    .out_power_released    (out_power_released),
    .out_reset_pressed     (out_reset_pressed),
    .out_debug_pressed     (out_debug_pressed),
    .out_activity_edge     (out_activity_edge),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers and the pin state
  logic [15:0]                   set_debounce_ms = mid_pkg::DEBOUNCE_MS_RST;
  logic [15:0]                   set_poll_ms = mid_pkg::POLL_INTERVAL_MS_RST;
  logic [mid_pkg::NUM_PINS-1:0]  set_polarity = mid_pkg::ACTIVE_HIGH_MASK_RST;
  logic                          seen_first = 1'b0;
  logic [mid_pkg::NUM_LANES-1:0] cand_lvl = '0;
  logic [mid_pkg::NUM_LANES-1:0] stab_lvl = '0;
  logic [31:0]                   change_at [mid_pkg::NUM_LANES] = '{default: '0};
  logic [31:0]                   last_poll_at = '0;
  logic                          act_edge_sticky = 1'b0;
  logic                          prev_act = 1'b0;

  pin_sample_t       sample_queue [$];
  mid_pkg::result_t  levels_due [$];
  pin_sample_t       in_flight;
  mid_pkg::result_t  check_want;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  logic [31:0] stim_clock;
  logic [5:0]  stim_pins;

  function automatic mid_pkg::result_t debounce_sample(input pin_sample_t s);
    mid_pkg::result_t              r;
    logic [mid_pkg::NUM_PINS-1:0]  norm;
    logic [mid_pkg::NUM_LANES-1:0] rise;
    logic [mid_pkg::NUM_LANES-1:0] fall;
    logic                          act;
    logic                          lvl;
    logic [31:0]                   dt;
    r = '0;
    rise = '0;
    fall = '0;
    norm = s.raw ^ ~set_polarity;
    act = norm[mid_pkg::ACT_BIT];
    if (!seen_first) begin
      // first transaction only loads the lanes
      seen_first = 1'b1;
      for (int i = 0; i < mid_pkg::NUM_LANES; i++) begin
        lvl = norm[mid_pkg::LANE_PIN[i]];
        stab_lvl[i] = lvl;
        cand_lvl[i] = lvl;
        change_at[i] = s.now;
      end
    end else begin
      if (act && !prev_act) act_edge_sticky = 1'b1;
      dt = s.now - last_poll_at;
      if (dt >= {16'h0, set_poll_ms}) begin
        last_poll_at = s.now;
        for (int i = 0; i < mid_pkg::NUM_LANES; i++) begin
          lvl = norm[mid_pkg::LANE_PIN[i]];
          if (lvl != cand_lvl[i]) begin
            cand_lvl[i] = lvl;
            change_at[i] = s.now;
          end
          dt = s.now - change_at[i];
          if (stab_lvl[i] != cand_lvl[i] && dt >= {16'h0, set_debounce_ms}) begin
            rise[i] = cand_lvl[i];
            fall[i] = !cand_lvl[i];
            stab_lvl[i] = cand_lvl[i];
          end
        end
      end
    end
    prev_act = act;
    if (s.take) begin
      r.activity_edge = act_edge_sticky;
      act_edge_sticky = 1'b0;
    end
    for (int i = 0; i < mid_pkg::NUM_LANES; i++) begin
      r.stable_levels[mid_pkg::LANE_PIN[i]] = stab_lvl[i];
    end
    r.stable_levels[mid_pkg::ACT_BIT] = act;
    r.power_pressed = rise[mid_pkg::LANE_POWER_BTN];
    r.power_released = fall[mid_pkg::LANE_POWER_BTN];
    r.reset_pressed = rise[mid_pkg::LANE_RESET_BTN];
    r.debug_pressed = rise[mid_pkg::LANE_DEBUG_BTN];
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic write_reg(input logic [mid_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mid_pkg::CFG_DEBOUNCE_MS:      set_debounce_ms = val;
      mid_pkg::CFG_POLL_INTERVAL_MS: set_poll_ms = val;
      mid_pkg::CFG_ACTIVE_HIGH_MASK: set_polarity = val[mid_pkg::NUM_PINS-1:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(input logic [31:0] now, input logic [5:0] raw, input logic take);
    pin_sample_t s;
    s.now = now;
    s.raw = raw;
    s.take = take;
    sample_queue.push_back(s);
  endtask

  // time mostly creeps forward so presses settle; pins hold with occasional bounce
  task automatic queue_random_samples(input int unsigned count);
    int unsigned r;
    int unsigned span_short;
    int unsigned span_long;
    span_short = set_poll_ms / 2 + set_debounce_ms / 8 + 3;
    span_long = 2 * (set_poll_ms + set_debounce_ms) + 3;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) stim_clock += $urandom_range(0, span_short);
      else if (r < 95) stim_clock += $urandom_range(0, span_long);
      else stim_clock = $urandom();
      r = $urandom_range(0, 99);
      if (r < 12) stim_pins[$urandom_range(0, 5)] ^= 1'b1;
      else if (r < 16) stim_pins = 6'($urandom_range(0, 63));
      push_sample(stim_clock, stim_pins, $urandom_range(0, 3) == 0);
    end
  endtask

  // checked away from the rising edge so the driver and monitor have settled
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || levels_due.size() != 0 || out_valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) levels_due.push_back(debounce_sample(in_flight));
      if (!(in_valid && in_stall)) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_flight = sample_queue.pop_front();
          in_valid <= 1'b1;
          in_now_ms <= in_flight.now;
          in_raw_levels <= in_flight.raw;
          in_take_activity_edge <= in_flight.take;
          send_gap = pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'(out_stable_levels), '0);
        end else begin
          check_want = levels_due.pop_front();
          if (out_stable_levels !== check_want.stable_levels)
            flag_mismatch("stable_levels", 32'(out_stable_levels),
                          32'(check_want.stable_levels));
          if (out_power_pressed !== check_want.power_pressed)
            flag_mismatch("power_pressed", 32'(out_power_pressed),
                          32'(check_want.power_pressed));
          if (out_power_released !== check_want.power_released)
            flag_mismatch("power_released", 32'(out_power_released),
                          32'(check_want.power_released));
          if (out_reset_pressed !== check_want.reset_pressed)
            flag_mismatch("reset_pressed", 32'(out_reset_pressed),
                          32'(check_want.reset_pressed));
          if (out_debug_pressed !== check_want.debug_pressed)
            flag_mismatch("debug_pressed", 32'(out_debug_pressed),
                          32'(check_want.debug_pressed));
          if (out_activity_edge !== check_want.activity_edge)
            flag_mismatch("activity_edge", 32'(out_activity_edge),
                          32'(check_want.activity_edge));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold_left = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: first transaction, presses, releases, bounce, wrap
    push_sample(32'd1000, 6'b000000, 1'b1);
    push_sample(32'd1005, 6'b001010, 1'b1);  // activity rise taken at once, power press starts settling
    push_sample(32'd1010, 6'b001010, 1'b0);
    push_sample(32'd1030, 6'b001000, 1'b0);
    push_sample(32'd1040, 6'b001010, 1'b0);  // power press
    push_sample(32'd1041, 6'b001010, 1'b1);
    push_sample(32'd1050, 6'b000000, 1'b0);
    push_sample(32'd1085, 6'b000000, 1'b0);  // power release
    push_sample(32'd1090, 6'b111111, 1'b0);
    push_sample(32'd1095, 6'b111111, 1'b0);
    push_sample(32'd1125, 6'b111111, 1'b1);  // all buttons press together
    push_sample(32'd1135, 6'b110111, 1'b0);
    push_sample(32'd1145, 6'b111111, 1'b0);  // bounce back, no pulse
    push_sample(32'hFFFF_FFF0, 6'b000000, 1'b0);
    push_sample(32'h0000_0010, 6'b000000, 1'b0);  // releases across the wrap
    push_sample(32'h0000_0011, 6'b000010, 1'b1);
    push_sample(32'hFFFF_FFFF, 6'b111111, 1'b1);
    push_sample(32'h0000_0000, 6'b111111, 1'b0);
    push_sample(32'h0000_0040, 6'b101101, 1'b1);
    stim_clock = 32'h0000_0040;
    stim_pins = 6'b101101;
    queue_random_samples(100);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_reg(mid_pkg::CFG_DEBOUNCE_MS, 16'd0);
          write_reg(mid_pkg::CFG_POLL_INTERVAL_MS, 16'd0);
          write_reg(mid_pkg::CFG_ACTIVE_HIGH_MASK, 16'h0000);
        end
        1: begin
          write_reg(mid_pkg::CFG_DEBOUNCE_MS, 16'hFFFF);
          write_reg(mid_pkg::CFG_POLL_INTERVAL_MS, 16'hFFFF);
          write_reg(mid_pkg::CFG_ACTIVE_HIGH_MASK, 16'h003F);
        end
        2: begin
          write_reg(mid_pkg::CFG_DEBOUNCE_MS, 16'd0);
          write_reg(mid_pkg::CFG_POLL_INTERVAL_MS, 16'hFFFF);
          write_reg(mid_pkg::CFG_ACTIVE_HIGH_MASK, 16'($urandom_range(0, 63)));
        end
        3: begin
          write_reg(mid_pkg::CFG_DEBOUNCE_MS, 16'hFFFF);
          write_reg(mid_pkg::CFG_POLL_INTERVAL_MS, 16'd0);
          write_reg(mid_pkg::CFG_ACTIVE_HIGH_MASK, 16'($urandom_range(0, 63)));
        end
        default: begin
          write_reg(mid_pkg::CFG_DEBOUNCE_MS, ($urandom_range(0, 7) == 0) ?
                    16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60)));
          write_reg(mid_pkg::CFG_POLL_INTERVAL_MS, ($urandom_range(0, 7) == 0) ?
                    16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 25)));
          write_reg(mid_pkg::CFG_ACTIVE_HIGH_MASK, 16'($urandom_range(0, 63)));
        end
      endcase
      no_idle = (phase % 3 == 2);
      queue_random_samples(140);
      drain();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
